>>> rtl/lfs_pkg.sv
package lfs_pkg;

  // Sensor-point angle limit, pi/2 in Q12
  localparam logic signed [33:0] ClampHi = 34'sd6434;
  localparam logic signed [33:0] ClampLo = -34'sd6434;

  // Register reset values
  localparam logic [12:0] XiReset   = 13'd3277;
  localparam logic [10:0] WbReset   = 11'd250;
  localparam logic [10:0] SdReset   = 11'd100;
  localparam logic [18:0] BaseReset = 19'd0;

  // Gain divider depth: one quotient bit per stage
  localparam int GainDivStages  = 32;
  // Steer divider depth
  localparam int SteerDivStages = 13;

  // Register map, word index on paddr[3:2]
  typedef enum logic [1:0] {
    REG_XI   = 2'd0,
    REG_WB   = 2'd1,
    REG_SD   = 2'd2,
    REG_BASE = 2'd3
  } reg_idx_t;

  // One word in flight through the gain dividers
  typedef struct packed {
    logic [76:0] rem_hi;   // |p| * 2^24, reduced as bits resolve
    logic [63:0] den_hi;   // 1000 * u^2 * xi^2
    logic [31:0] q_hi;
    logic        sat;
    logic [28:0] rem_lo;   // |12 * L * angle|
    logic [13:0] den_lo;   // |u|
    logic [28:0] q_lo;
    logic        neg_hi;
    logic        neg_lo;
    logic        low;
    logic [11:0] len;
    logic [10:0] wb;
  } div_t;

  // One word in flight through the steer divider
  typedef struct packed {
    logic [23:0] rem;
    logic [11:0] den;
    logic [12:0] q;
    logic        neg;
    logic        low;
    logic        clamped;
  } sdiv_t;

endpackage

>>> rtl/lfs_if.sv
interface lfs_in_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] speed_mm_s;
  logic signed [18:0] line_offset_um;
  logic signed [13:0] line_angle_q12;

  modport source (output valid, speed_mm_s, line_offset_um, line_angle_q12, input ready);
  modport sink   (input valid, speed_mm_s, line_offset_um, line_angle_q12, output ready);
endinterface

interface lfs_out_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] steer_angle_q12;
  logic               was_clamped;
  logic               below_min_speed;

  modport source (output valid, steer_angle_q12, was_clamped, below_min_speed, input ready);
  modport sink   (input valid, steer_angle_q12, was_clamped, below_min_speed, output ready);
endinterface

>>> rtl/line_follow_steering_law.sv
// Line-following steering law, pole-placement gains.
//
// in_word carries one sample (speed, line offset, line angle); out_word
// returns one steering word per sample, in order. Both use valid/ready, a
// word moves at an edge where both are high. The user must write registers
// over the APB port (pready tied high) with no sample in flight; not enforced.
//
// A sample passes the gain-product stages A to E, 32 stages of the gain
// dividers (one quotient bit per stage), the sum/clamp and scaling stages F
// and G, 13 stages of the wheel-base divider and the output register. A new
// sample is taken every cycle unless a waiting output word is stalled.
//
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// register defaults. When the receiver holds out_word.ready low with a word
// waiting, the whole pipeline freezes and in_word.ready drops; nothing is
// lost or repeated, and flow resumes on the cycle ready returns.
module line_follow_steering_law
  import lfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lfs_in_if.sink      in_word,
  lfs_out_if.source   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- configuration registers ----------------
  logic [12:0] xi_r;
  logic [10:0] wb_r;
  logic [10:0] sd_r;
  logic [18:0] base_r;
  reg_idx_t    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xi_r   <= XiReset;
      wb_r   <= WbReset;
      sd_r   <= SdReset;
      base_r <= BaseReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_XI:   xi_r   <= pwdata[12:0];
        REG_WB:   wb_r   <= pwdata[10:0];
        REG_SD:   sd_r   <= pwdata[10:0];
        REG_BASE: base_r <= pwdata[18:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_XI:   prdata = 32'(xi_r);
      REG_WB:   prdata = 32'(wb_r);
      REG_SD:   prdata = 32'(sd_r);
      REG_BASE: prdata = 32'(base_r);
      default:  prdata = '0;
    endcase
  end

  // ---------------- pipeline advance ----------------
  logic out_vld_r;
  logic adv;

  assign adv           = !out_vld_r || out_word.ready;
  assign in_word.ready = adv;

  // ---------------- stage A: operand prep ----------------
  logic signed [14:0] u_w;
  logic signed [14:0] unz_w;
  logic               a_vld_r, a_negu_r, a_low_r;
  logic [13:0]        a_au_r;
  logic [12:0]        a_x_r;
  logic [11:0]        a_len_r;
  logic [10:0]        a_wb_r;
  logic signed [19:0] a_e_r;
  logic signed [13:0] a_ang_r;

  assign u_w   = $signed({in_word.speed_mm_s[13], in_word.speed_mm_s}) + 15'sd1000;
  assign unz_w = (u_w == 15'sd0) ? 15'sd1 : u_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_negu_r <= unz_w[14];
      a_au_r   <= unz_w[14] ? 14'(-unz_w) : unz_w[13:0];
      a_low_r  <= (in_word.speed_mm_s > -14'sd5) && (in_word.speed_mm_s < 14'sd5);
      a_x_r    <= (xi_r == 13'd0) ? 13'd1 : xi_r;
      a_len_r  <= 12'(wb_r) + 12'(sd_r);
      a_wb_r   <= wb_r;
      a_e_r    <= $signed({base_r[18], base_r}) -
                  $signed({in_word.line_offset_um[18], in_word.line_offset_um});
      a_ang_r  <= in_word.line_angle_q12;
    end
  end

  // ---------------- stage B: squares, L*angle ----------------
  logic               b_vld_r, b_negu_r, b_low_r;
  logic [27:0]        b_au2_r;
  logic [25:0]        b_x2_r;
  logic signed [26:0] b_la_r;
  logic [13:0]        b_au_r;
  logic [11:0]        b_len_r;
  logic [10:0]        b_wb_r;
  logic signed [19:0] b_e_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_au2_r  <= 28'(a_au_r) * 28'(a_au_r);
      b_x2_r   <= 26'(a_x_r) * 26'(a_x_r);
      b_la_r   <= $signed({1'b0, a_len_r}) * a_ang_r;
      b_negu_r <= a_negu_r;
      b_low_r  <= a_low_r;
      b_au_r   <= a_au_r;
      b_len_r  <= a_len_r;
      b_wb_r   <= a_wb_r;
      b_e_r    <= a_e_r;
    end
  end

  // ---------------- stage C: u^2*xi^2, m, -12*L*angle ----------------
  logic               c_vld_r, c_negu_r, c_low_r;
  logic [53:0]        c_d1_r;
  logic signed [37:0] c_m_r;
  logic signed [30:0] c_n2_r;
  logic [13:0]        c_au_r;
  logic [11:0]        c_len_r;
  logic [10:0]        c_wb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_d1_r   <= 54'(b_au2_r) * 54'(b_x2_r);
      c_m_r    <= 38'(b_la_r) * 38'sd1000 - (38'(b_e_r) <<< 12);
      c_n2_r   <= -(31'(b_la_r) * 31'sd12);
      c_negu_r <= b_negu_r;
      c_low_r  <= b_low_r;
      c_au_r   <= b_au_r;
      c_len_r  <= b_len_r;
      c_wb_r   <= b_wb_r;
    end
  end

  // ---------------- stage D: divisor, L*m ----------------
  logic               d_vld_r, d_neglo_r, d_low_r;
  logic [63:0]        d_den_r;
  logic signed [50:0] d_lm_r;
  logic [28:0]        d_n2mag_r;
  logic [13:0]        d_au_r;
  logic [11:0]        d_len_r;
  logic [10:0]        d_wb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_den_r   <= 64'(c_d1_r) * 64'd1000;
      d_lm_r    <= $signed({1'b0, c_len_r}) * c_m_r;
      d_n2mag_r <= c_n2_r[30] ? 29'(-c_n2_r) : c_n2_r[28:0];
      d_neglo_r <= c_n2_r[30] ^ c_negu_r;
      d_low_r   <= c_low_r;
      d_au_r    <= c_au_r;
      d_len_r   <= c_len_r;
      d_wb_r    <= c_wb_r;
    end
  end

  // ---------------- stage E: numerator, divider load ----------------
  logic signed [55:0] p_w;
  logic [52:0]        magp_w;
  logic               e_vld_r;
  div_t               e_div_r;

  assign p_w    = 56'(d_lm_r) * 56'sd36;
  assign magp_w = p_w[55] ? 53'(-p_w) : p_w[52:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      e_div_r.rem_hi <= {magp_w, 24'd0};
      e_div_r.den_hi <= d_den_r;
      e_div_r.q_hi   <= '0;
      e_div_r.sat    <= 1'b0;
      e_div_r.rem_lo <= d_n2mag_r;
      e_div_r.den_lo <= d_au_r;
      e_div_r.q_lo   <= '0;
      e_div_r.neg_hi <= p_w[55];
      e_div_r.neg_lo <= d_neglo_r;
      e_div_r.low    <= d_low_r;
      e_div_r.len    <= d_len_r;
      e_div_r.wb     <= d_wb_r;
    end
  end

  // ---------------- gain dividers ----------------
  logic dv_vld;
  div_t dv_data;

  lfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (e_vld_r),
    .in_data  (e_div_r),
    .out_vld  (dv_vld),
    .out_data (dv_data)
  );

  // ---------------- stage F: sum and clamp ----------------
  logic signed [33:0] t13_w, t2_w, s_w;
  logic               f_vld_r, f_clamp_r, f_low_r;
  logic signed [13:0] f_s_r;
  logic [11:0]        f_len_r;
  logic [10:0]        f_wb_r;

  always_comb begin
    t13_w = $signed({2'b00, dv_data.q_hi});
    if (dv_data.neg_hi) begin
      t13_w = -t13_w;
    end
    t2_w = $signed({5'd0, dv_data.q_lo});
    if (dv_data.neg_lo) begin
      t2_w = -t2_w;
    end
    s_w = t13_w + t2_w;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s_w > ClampHi) begin
        f_s_r     <= 14'(ClampHi);
        f_clamp_r <= 1'b1;
      end else if (s_w < ClampLo) begin
        f_s_r     <= 14'(ClampLo);
        f_clamp_r <= 1'b1;
      end else begin
        f_s_r     <= 14'(s_w);
        f_clamp_r <= 1'b0;
      end
      f_low_r <= dv_data.low;
      f_len_r <= dv_data.len;
      f_wb_r  <= dv_data.wb;
    end
  end

  // ---------------- stage G: scale by wheel base ----------------
  logic signed [25:0] prod_w;
  logic               g_vld_r;
  sdiv_t              g_div_r;

  assign prod_w = f_s_r * $signed({1'b0, f_wb_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      g_div_r.rem     <= prod_w[25] ? 24'(-prod_w) : prod_w[23:0];
      g_div_r.den     <= f_len_r;
      g_div_r.q       <= '0;
      g_div_r.neg     <= prod_w[25];
      g_div_r.low     <= f_low_r;
      g_div_r.clamped <= f_clamp_r;
    end
  end

  // ---------------- steer divider, divide by L ----------------
  sdiv_t sp_r  [SteerDivStages];
  logic  spv_r [SteerDivStages];

  for (genvar i = 0; i < SteerDivStages; i++) begin : g_sdiv
    localparam int K = SteerDivStages - 1 - i;
    sdiv_t src;
    sdiv_t nxt;
    logic  src_vld;

    if (i == 0) begin : g_first
      assign src     = g_div_r;
      assign src_vld = g_vld_r;
    end else begin : g_rest
      assign src     = sp_r[i-1];
      assign src_vld = spv_r[i-1];
    end

    always_comb begin
      nxt = src;
      if ((src.rem >> K) >= 24'(src.den)) begin
        nxt.rem  = src.rem - (24'(src.den) << K);
        nxt.q[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        spv_r[i] <= 1'b0;
      end else if (adv) begin
        spv_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sp_r[i] <= nxt;
      end
    end
  end

  // ---------------- valid chain outside the divider stages ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      f_vld_r   <= 1'b0;
      g_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r   <= in_word.valid;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      d_vld_r   <= c_vld_r;
      e_vld_r   <= d_vld_r;
      f_vld_r   <= dv_vld;
      g_vld_r   <= f_vld_r;
      out_vld_r <= spv_r[SteerDivStages-1];
    end
  end

  // ---------------- output register ----------------
  sdiv_t              last_w;
  logic signed [13:0] mag_w;
  logic signed [13:0] steer_r;
  logic               clamp_r, below_r;

  assign last_w = sp_r[SteerDivStages-1];
  assign mag_w  = $signed({1'b0, last_w.q});

  always_ff @(posedge clk) begin
    if (adv) begin
      if (last_w.low || (last_w.den == 12'd0)) begin
        steer_r <= '0;
      end else begin
        steer_r <= last_w.neg ? -mag_w : mag_w;
      end
      clamp_r <= last_w.clamped && !last_w.low;
      below_r <= last_w.low;
    end
  end

  assign out_word.valid           = out_vld_r;
  assign out_word.steer_angle_q12 = steer_r;
  assign out_word.was_clamped     = clamp_r;
  assign out_word.below_min_speed = below_r;

endmodule

>>> rtl/lfs_div.sv
module lfs_div
  import lfs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic in_vld,
  input  div_t in_data,
  output logic out_vld,
  output div_t out_data
);

  div_t pipe_r [GainDivStages];
  logic vld_r  [GainDivStages];

  // Two restoring dividers side by side, one quotient bit per stage each (low one from bit 28 down)
  for (genvar i = 0; i < GainDivStages; i++) begin : g_stg
    localparam int K   = GainDivStages - 1 - i;
    localparam int LoK = (K > 28) ? 0 : K;
    div_t src;
    div_t nxt;
    logic src_vld;

    if (i == 0) begin : g_first
      assign src     = in_data;
      assign src_vld = in_vld;
    end else begin : g_rest
      assign src     = pipe_r[i-1];
      assign src_vld = vld_r[i-1];
    end

    always_comb begin
      nxt = src;
      // top bit only detects overflow; the result then saturates at 2^31
      if (K == GainDivStages - 1) begin
        if ((src.rem_hi >> K) >= 77'(src.den_hi)) begin
          nxt.sat     = 1'b1;
          nxt.q_hi[K] = 1'b1;
        end
      end else if (!src.sat && ((src.rem_hi >> K) >= 77'(src.den_hi))) begin
        nxt.rem_hi  = src.rem_hi - (77'(src.den_hi) << K);
        nxt.q_hi[K] = 1'b1;
      end
      if (K <= 28) begin
        if ((src.rem_lo >> LoK) >= 29'(src.den_lo)) begin
          nxt.rem_lo    = src.rem_lo - (29'(src.den_lo) << LoK);
          nxt.q_lo[LoK] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[i] <= nxt;
      end
    end
  end

  assign out_vld  = vld_r[GainDivStages-1];
  assign out_data = pipe_r[GainDivStages-1];

endmodule

>>> rtl/lfs_checker.sv
module lfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] steer,
  input logic        clamped,
  input logic        below
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // a waiting word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(steer) && $stable(clamped)
      && $stable(below))
    else $error("stalled result word changed");

  // low speed forces a zero steer with no clamp
  a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && below |-> (steer == 14'd0) && !clamped)
    else $error("low-speed word not zero");

  // steer never exceeds pi/2
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(steer) <= 14'sd6434) && ($signed(steer) >= -14'sd6434))
    else $error("steer out of range");

endmodule

bind line_follow_steering_law lfs_checker u_lfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .steer     (out_word.steer_angle_q12),
  .clamped   (out_word.was_clamped),
  .below     (out_word.below_min_speed)
);
